[rtl/spn_pkg.sv]
// Package for the SPN block cipher engine: widths, function codes and helpers.
// Used by the datapath, controller, top level and checker; depends on nothing.
package spn_pkg;
  localparam int unsigned BlkBytes = 16;
  localparam int unsigned NibCnt = 32;
  localparam int unsigned DefMaxRounds = 16;
  localparam int unsigned CfgW = 5;

  localparam logic [2:0] FUNC_LOAD_SUB = 3'd0;
  localparam logic [2:0] FUNC_LOAD_PERM = 3'd1;
  localparam logic [2:0] FUNC_LOAD_KEY = 3'd2;
  localparam logic [2:0] FUNC_ENCRYPT = 3'd3;
  localparam logic [2:0] FUNC_DECRYPT = 3'd4;

  localparam logic CFG_ROUND_COUNT = 1'b0;
  localparam logic CFG_PERM_PERIOD = 1'b1;

  localparam logic [4:0] RESET_ROUNDS = 5'd16;
  localparam logic [4:0] RESET_PERIOD = 5'd2;

  typedef logic [7:0] byte_t;
  typedef byte_t [BlkBytes-1:0] blk_t;

  typedef enum logic [1:0] {
    RND_PLAIN = 2'd0,
    RND_PERM = 2'd1,
    RND_SLIDE = 2'd2
  } rnd_kind_t;

  typedef struct packed {
    logic load;
    logic start;
    logic fwd;
    logic rd;
    logic [3:0] rd_idx;
    logic wb;
    logic [3:0] wb_idx;
    logic sub_en;
    logic mix;
    rnd_kind_t kind;
    logic [3:0] rnd_idx;
  } ctl_cmd_t;

  function automatic blk_t slide_fwd(input blk_t b);
    blk_t o;
    o = b;
    for (int i = 1; i < 14; i++) begin
      o[i+1] = o[i+1] ^ o[i];
    end
    o[0] = o[0] ^ o[15];
    return o;
  endfunction

  function automatic blk_t slide_inv(input blk_t b);
    blk_t o;
    o = b;
    o[0] = o[0] ^ o[15];
    for (int i = 14; i >= 2; i--) begin
      o[i] = o[i] ^ o[i-1];
    end
    return o;
  endfunction
endpackage

[rtl/spn_if.sv]
// Valid/ready channel interfaces for the SPN block cipher engine.
// Depends on no other file.
interface spn_in_if;
  logic valid;
  logic ready;
  logic [2:0] func;
  logic [7:0] index;
  logic [7:0] table_value;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source(output valid, func, index, table_value, block_hi, block_lo, input ready);
  modport sink(input valid, func, index, table_value, block_hi, block_lo, output ready);
endinterface

interface spn_out_if;
  logic valid;
  logic ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source(output valid, result_hi, result_lo, input ready);
  modport sink(input valid, result_hi, result_lo, output ready);
endinterface

interface spn_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [4:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/spn_datapath.sv]
// Datapath of the SPN engine: tables, key store, round key buffer and the state register.
// Depends on spn_pkg; commanded by spn_ctrl.
module spn_datapath
  import spn_pkg::*;
(
  input  logic        clk,
  input  ctl_cmd_t    cmd,
  input  logic [2:0]  func,
  input  logic [7:0]  index,
  input  logic [7:0]  table_value,
  input  logic [63:0] block_hi,
  input  logic [63:0] block_lo,
  output blk_t        state_q
);
  byte_t sub_mem [256];
  byte_t isub_mem [256];
  logic [4:0] perm_mem [NibCnt];
  logic [4:0] iperm_mem [NibCnt];
  byte_t key_mem [256];
  blk_t st_r;
  blk_t st_nxt;
  blk_t kbuf_r;
  blk_t load_blk;
  blk_t pre_mix;
  blk_t mixed;
  byte_t sub_rd_r;
  byte_t key_rd_r;
  byte_t rd_addr;
  logic [3:0] in_nib [NibCnt];
  logic [3:0] out_nib [NibCnt];

  assign state_q = st_r;
  assign rd_addr = st_r[cmd.rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (func)
        FUNC_LOAD_SUB: begin
          sub_mem[index] <= table_value;
          isub_mem[table_value] <= index;
        end
        FUNC_LOAD_PERM: begin
          perm_mem[index[4:0]] <= table_value[4:0];
          iperm_mem[table_value[4:0]] <= index[4:0];
        end
        FUNC_LOAD_KEY: key_mem[index] <= table_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      if (cmd.fwd) sub_rd_r <= sub_mem[rd_addr];
      else sub_rd_r <= isub_mem[rd_addr];
      key_rd_r <= key_mem[{cmd.rnd_idx, cmd.rd_idx}];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      load_blk[i] = block_hi[63-8*i -: 8];
      load_blk[8+i] = block_lo[63-8*i -: 8];
    end
    for (int n = 0; n < BlkBytes; n++) begin
      pre_mix[n] = cmd.fwd ? st_r[n] : (st_r[n] ^ kbuf_r[n]);
    end
    for (int i = 0; i < BlkBytes; i++) begin
      in_nib[2*i] = pre_mix[i][7:4];
      in_nib[2*i+1] = pre_mix[i][3:0];
    end
    for (int j = 0; j < NibCnt; j++) begin
      out_nib[j] = 4'd0;
      for (int i = 0; i < NibCnt; i++) begin
        if ((cmd.fwd ? perm_mem[i] : iperm_mem[i]) == j[4:0]) out_nib[j] = in_nib[i];
      end
    end
    case (cmd.kind)
      RND_PERM: for (int i = 0; i < BlkBytes; i++) mixed[i] = {out_nib[2*i], out_nib[2*i+1]};
      RND_SLIDE: mixed = cmd.fwd ? slide_fwd(pre_mix) : slide_inv(pre_mix);
      default: mixed = pre_mix;
    endcase
    for (int n = 0; n < BlkBytes; n++) begin
      st_nxt[n] = cmd.fwd ? (mixed[n] ^ kbuf_r[n]) : mixed[n];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      st_r <= load_blk;
    end else if (cmd.mix) begin
      st_r <= st_nxt;
    end else if (cmd.wb && cmd.sub_en) begin
      st_r[cmd.wb_idx] <= sub_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      kbuf_r[cmd.wb_idx] <= key_rd_r;
    end
  end
endmodule

[rtl/spn_ctrl.sv]
// Controller of the SPN engine: round and byte sequencing, handshakes and result flag.
// Depends on spn_pkg; drives spn_datapath.
module spn_ctrl
  import spn_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = DefMaxRounds
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] func,
  input  logic [4:0] round_count,
  input  logic [4:0] perm_period,
  input  logic       out_ready,
  output logic       out_valid,
  output ctl_cmd_t   cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BYTES = 2'd1;
  localparam logic [1:0] S_MIX = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [4:0] rnd_r, rnd_nxt;
  logic [4:0] last_r, last_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic dec_r, dec_nxt;
  logic sub_en_r, sub_en_nxt;
  logic ov_r, ov_nxt;
  logic acc;
  logic [4:0] rounds;
  logic period_hit;
  logic use_perm;
  logic busy_done;

  assign rounds = (round_count > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : round_count;
  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign acc = in_valid && in_ready;
  assign out_valid = ov_r;
  assign use_perm = (perm_period != 5'd0) && period_hit && (rnd_r[1:0] != 2'd0);

  always_comb begin
    period_hit = 1'b0;
    for (int k = 1; k <= int'(MAX_ROUNDS); k++) begin
      if ({4'd0, perm_period} * 9'(k) == {4'd0, rnd_r}) period_hit = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    rnd_nxt = rnd_r;
    last_nxt = last_r;
    cnt_nxt = cnt_r;
    dec_nxt = dec_r;
    sub_en_nxt = sub_en_r;
    ov_nxt = ov_r && !out_ready;
    busy_done = 1'b0;
    cmd = '0;
    cmd.fwd = !dec_r;
    cmd.sub_en = sub_en_r;
    cmd.rnd_idx = 4'(rnd_r - 5'd1);
    cmd.rd_idx = cnt_r[3:0];
    cmd.wb_idx = 4'(cnt_r - 5'd1);
    cmd.kind = use_perm ? RND_PERM : ((rnd_r[1:0] == 2'd0) ? RND_SLIDE : RND_PLAIN);
    cmd.load = acc && (func == FUNC_LOAD_SUB || func == FUNC_LOAD_PERM
                       || func == FUNC_LOAD_KEY);
    unique case (st_r)
      S_IDLE: begin
        if (acc && (func == FUNC_ENCRYPT || func == FUNC_DECRYPT)) begin
          cmd.start = 1'b1;
          dec_nxt = (func == FUNC_DECRYPT);
          sub_en_nxt = (func == FUNC_ENCRYPT);
          rnd_nxt = (func == FUNC_ENCRYPT) ? 5'd1 : rounds;
          last_nxt = rounds;
          cnt_nxt = 5'd0;
          if (rounds == 5'd0) ov_nxt = 1'b1;
          else st_nxt = S_BYTES;
        end
      end
      S_BYTES: begin
        cmd.rd = !cnt_r[4];
        cmd.wb = (cnt_r != 5'd0);
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[4]) begin
          cnt_nxt = 5'd0;
          if (dec_r && rnd_r == 5'd0) begin
            st_nxt = S_IDLE;
            busy_done = 1'b1;
          end else st_nxt = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        if (dec_r) begin
          rnd_nxt = rnd_r - 5'd1;
          sub_en_nxt = 1'b1;
          st_nxt = S_BYTES;
        end else if (rnd_r == last_r) begin
          st_nxt = S_IDLE;
          busy_done = 1'b1;
        end else begin
          rnd_nxt = rnd_r + 5'd1;
          st_nxt = S_BYTES;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (busy_done) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      rnd_r <= '0;
      last_r <= '0;
      cnt_r <= '0;
      dec_r <= 1'b0;
      sub_en_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      rnd_r <= rnd_nxt;
      last_r <= last_nxt;
      cnt_r <= cnt_nxt;
      dec_r <= dec_nxt;
      sub_en_r <= sub_en_nxt;
    end
  end
endmodule

[rtl/spn_block_cipher_engine_core.sv]
// Top level of the SPN block cipher engine: config registers, controller, datapath.
// Depends on spn_pkg, spn_if, spn_ctrl and spn_datapath.
//
//   channel | direction | carries
//   in_     | sink      | func, index, table_value, block_hi, block_lo
//   out_    | source    | result_hi, result_lo (encrypt and decrypt only)
//   cfg_    | sink      | index 0 round_count, index 1 perm_period
//
// A load is written to its table as it is accepted, and a block is loaded into the state
// register as it is accepted; each round then reads the substitution and key tables one
// byte per cycle through a read register and then mixes the block in the mix state.
// Decryption adds a pass of byte reads to fetch the first round keys. Reset sets
// round_count to 16 and perm_period to 2; tables are undefined until written. A waiting
// result holds off the next input transaction.
module spn_block_cipher_engine_core
  import spn_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = DefMaxRounds
) (
  input logic clk,
  input logic rst_n,
  spn_in_if.sink in_ch,
  spn_out_if.source out_ch,
  spn_cfg_if.sink cfg_ch
);
  logic [4:0] round_count_r;
  logic [4:0] perm_period_r;
  ctl_cmd_t cmd;
  blk_t st;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= RESET_ROUNDS;
      perm_period_r <= RESET_PERIOD;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ROUND_COUNT: round_count_r <= cfg_ch.data;
        CFG_PERM_PERIOD: perm_period_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  spn_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .func(in_ch.func), .round_count(round_count_r), .perm_period(perm_period_r),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .cmd(cmd)
  );

  spn_datapath u_dp (
    .clk(clk), .cmd(cmd), .func(in_ch.func), .index(in_ch.index),
    .table_value(in_ch.table_value), .block_hi(in_ch.block_hi),
    .block_lo(in_ch.block_lo), .state_q(st)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      out_ch.result_hi[63-8*i -: 8] = st[i];
      out_ch.result_lo[63-8*i -: 8] = st[8+i];
    end
  end
endmodule

[rtl/spn_checker.sv]
// Port-level checker for the SPN block cipher engine, bound to the top level.
// Depends on spn_pkg and the channel interfaces.
module spn_checker
  import spn_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] result_hi
);
  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_hi))
    else $error("result dropped");
  a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");
endmodule

bind spn_block_cipher_engine_core spn_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .result_hi(out_ch.result_hi)
);
